>>> src/bcc_pkg.sv
// Shared types and constants for the button click counter.
package bcc_pkg;

  localparam int TS_W      = 24;
  localparam int CLICK_W   = 8;
  localparam int SEC_W     = 9;
  localparam int SEC_SHIFT = 15;

  localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

  localparam logic [TS_W-1:0] TIMEOUT_RESET   = 24'd16384;
  localparam logic [TS_W-1:0] MIN_PRESS_RESET = 24'd3300;

  // event codes
  typedef enum logic [2:0] {
    OP_PRESS   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_TICK    = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT   = 1'b0,
    REG_MIN_PRESS = 1'b1
  } reg_idx_t;

endpackage

>>> src/button_click_counter.sv
// Button click counter: burst detection from timestamped button events.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless out_stall holds the result register;
// the only loop is the state update.
// Reset (rst, synchronous): configuration returns to its defaults, the block
// comes up enabled with no clicks, no timer and no report waiting.
module button_click_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [bcc_pkg::TS_W-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 operation,
  input  logic [bcc_pkg::TS_W-1:0]   timestamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       report_ready,
  output logic [bcc_pkg::CLICK_W-1:0] report_clicks,
  output logic [bcc_pkg::SEC_W-1:0]  report_seconds,
  output logic                       report_new,
  output logic [bcc_pkg::CLICK_W-1:0] clicks_pending,
  output logic                       enabled_now
);
  import bcc_pkg::*;

  // configuration
  logic [TS_W-1:0] timeout_ticks;
  logic [TS_W-1:0] min_press_ticks;

  // input register
  logic            s1_valid;
  logic [2:0]      s1_op;
  logic [TS_W-1:0] s1_ts;

  // block state
  logic               enabled,        enabled_next;
  logic               press_seen,     press_seen_next;
  logic [CLICK_W-1:0] click_count,    click_count_next;
  logic [TS_W-1:0]    press_start,    press_start_next;
  logic [TS_W-1:0]    press_length,   press_length_next;
  logic               timer_armed,    timer_armed_next;
  logic [TS_W-1:0]    timer_start,    timer_start_next;
  logic               report_flag,    report_flag_next;
  logic [CLICK_W-1:0] latched_clicks, latched_clicks_next;
  logic [SEC_W-1:0]   latched_seconds, latched_seconds_next;
  logic               fresh;

  logic            out_load;
  logic            proc;
  logic [TS_W-1:0] press_delta;
  logic [TS_W-1:0] timer_delta;

  // handshake: result register takes a new item when empty or being drained
  assign out_load = !out_valid || !out_stall;
  assign proc     = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;

  // write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      min_press_ticks <= MIN_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:   timeout_ticks   <= cfg_data;
        REG_MIN_PRESS: min_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op <= operation;
      s1_ts <= timestamp;
    end
  end

  // elapsed times, modulo the timestamp width
  assign press_delta = s1_ts - press_start;
  assign timer_delta = s1_ts - timer_start;

  // apply one event to the state
  always_comb begin
    enabled_next         = enabled;
    press_seen_next      = press_seen;
    click_count_next     = click_count;
    press_start_next     = press_start;
    press_length_next    = press_length;
    timer_armed_next     = timer_armed;
    timer_start_next     = timer_start;
    report_flag_next     = report_flag;
    latched_clicks_next  = latched_clicks;
    latched_seconds_next = latched_seconds;
    fresh                = 1'b0;
    unique case (s1_op)
      OP_PRESS: begin
        if (enabled) begin
          press_seen_next = 1'b1;
          if (click_count != CLICK_MAX) click_count_next = click_count + 1'b1;
          press_start_next = s1_ts;
          timer_armed_next = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (enabled && press_seen) begin
          timer_armed_next  = 1'b1;
          timer_start_next  = s1_ts;
          press_length_next = press_delta;
          // take back a press that was too short
          if (press_delta < min_press_ticks && click_count != '0)
            click_count_next = click_count - 1'b1;
          press_seen_next = 1'b0;
        end
      end
      OP_TICK: begin
        if (timer_armed && timer_delta >= timeout_ticks) begin
          timer_armed_next = 1'b0;
          if (!report_flag && enabled) begin
            latched_clicks_next  = click_count;
            latched_seconds_next = press_length[SEC_SHIFT +: SEC_W];
            report_flag_next     = 1'b1;
            fresh                = 1'b1;
          end
          click_count_next  = '0;
          press_length_next = '0;
        end
      end
      OP_ENABLE: begin
        if (!enabled) begin
          click_count_next = '0;
          report_flag_next = 1'b0;
          press_start_next = s1_ts;
          enabled_next     = 1'b1;
        end
      end
      OP_DISABLE: begin
        enabled_next = 1'b0;
      end
      default: ;
    endcase
  end

  // commit state when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b1;
      press_seen      <= 1'b0;
      click_count     <= '0;
      press_start     <= '0;
      press_length    <= '0;
      timer_armed     <= 1'b0;
      timer_start     <= '0;
      report_flag     <= 1'b0;
      latched_clicks  <= '0;
      latched_seconds <= '0;
    end else if (proc) begin
      enabled         <= enabled_next;
      press_seen      <= press_seen_next;
      click_count     <= click_count_next;
      press_start     <= press_start_next;
      press_length    <= press_length_next;
      timer_armed     <= timer_armed_next;
      timer_start     <= timer_start_next;
      report_flag     <= report_flag_next;
      latched_clicks  <= latched_clicks_next;
      latched_seconds <= latched_seconds_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      report_ready   <= report_flag_next;
      report_clicks  <= latched_clicks_next;
      report_seconds <= latched_seconds_next;
      report_new     <= fresh;
      clicks_pending <= click_count_next;
      enabled_now    <= enabled_next;
    end
  end

  // a new report is always a waiting report
  a_new_is_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_new |-> report_ready)
    else $error("report_new without report_ready");

  // a processed disable leaves the block disabled
  a_disable: assert property (@(posedge clk) disable iff (rst)
    proc && s1_op == OP_DISABLE |=> !enabled)
    else $error("disable did not clear enabled");

  // a report appears only through a tick
  a_report_by_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(report_flag) |-> $past(proc && s1_op == OP_TICK))
    else $error("report latched without a tick");

  // the click count saturates instead of wrapping
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    proc && s1_op == OP_PRESS && click_count == CLICK_MAX |=> click_count == CLICK_MAX)
    else $error("click count wrapped");

endmodule

>>> bench/button_click_counter_tb.sv
// Self-checking testbench for the button click counter: random and directed event streams.
`timescale 1ns / 100ps

module button_click_counter_tb;
  import bcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 200;

  typedef struct packed {
    logic [2:0]      op;
    logic [TS_W-1:0] ts;
  } btn_event_t;

  typedef struct packed {
    logic               ready;
    logic [CLICK_W-1:0] clicks;
    logic [SEC_W-1:0]   seconds;
    logic               fresh;
    logic [CLICK_W-1:0] pending;
    logic               enabled;
  } status_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [TS_W-1:0] cfg_data;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = '0;
  logic [TS_W-1:0] timestamp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic report_ready;
  logic [CLICK_W-1:0] report_clicks;
  logic [SEC_W-1:0] report_seconds;
  logic report_new;
  logic [CLICK_W-1:0] clicks_pending;
  logic enabled_now;

  button_click_counter DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .report_ready(report_ready), .report_clicks(report_clicks),
    .report_seconds(report_seconds), .report_new(report_new),
    .clicks_pending(clicks_pending), .enabled_now(enabled_now)
  );

  always #10 clk = ~clk;

  // pending events, expected status items, bookkeeping
  btn_event_t event_q[$];
  status_t    status_q[$];
  int items_issued   = 0;
  int items_accepted = 0;
  int status_checked = 0;
  int fresh_reports  = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  bit hold_req       = 1'b0;
  bit hold_taken     = 1'b0;
  logic [TS_W-1:0] now_ts = '0;

  // predictor copy of configuration and state
  logic [TS_W-1:0]    cfg_timeout;
  logic [TS_W-1:0]    cfg_min_press;
  logic               btn_on;
  logic               held;
  logic [CLICK_W-1:0] burst_clicks;
  logic [TS_W-1:0]    press_t0;
  logic [TS_W-1:0]    last_len;
  logic               timer_run;
  logic [TS_W-1:0]    timer_t0;
  logic               report_held;
  logic [CLICK_W-1:0] rep_clicks;
  logic [SEC_W-1:0]   rep_secs;

  // Advance the click state by one event and return the status it leaves.
  function automatic status_t predict_click_state(logic [2:0] op, logic [TS_W-1:0] ts);
    status_t r;
    logic fresh;
    logic [TS_W-1:0] since;
    fresh = 1'b0;
    since = ts - timer_t0;
    case (op)
      OP_PRESS: begin
        if (btn_on) begin
          held = 1'b1;
          if (burst_clicks != CLICK_MAX) burst_clicks = burst_clicks + 1'b1;
          press_t0 = ts;
          timer_run = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (btn_on && held) begin
          timer_run = 1'b1;
          timer_t0 = ts;
          last_len = ts - press_t0;
          if (last_len < cfg_min_press && burst_clicks != '0)
            burst_clicks = burst_clicks - 1'b1;
          held = 1'b0;
        end
      end
      OP_TICK: begin
        if (timer_run && since >= cfg_timeout) begin
          timer_run = 1'b0;
          if (!report_held && btn_on) begin
            rep_clicks = burst_clicks;
            rep_secs = SEC_W'(last_len >> SEC_SHIFT);
            report_held = 1'b1;
            fresh = 1'b1;
          end
          burst_clicks = '0;
          last_len = '0;
        end
      end
      OP_ENABLE: begin
        if (!btn_on) begin
          burst_clicks = '0;
          report_held = 1'b0;
          press_t0 = ts;
          btn_on = 1'b1;
        end
      end
      OP_DISABLE: btn_on = 1'b0;
      default: ;
    endcase
    r.ready   = report_held;
    r.clicks  = rep_clicks;
    r.seconds = rep_secs;
    r.fresh   = fresh;
    r.pending = burst_clicks;
    r.enabled = btn_on;
    return r;
  endfunction

  task automatic push_event(logic [2:0] op, logic [TS_W-1:0] ts);
    btn_event_t e;
    e.op = op;
    e.ts = ts;
    event_q.push_back(e);
    items_issued++;
  endtask

  // Hold until every issued item is accepted and every status item checked.
  task automatic wait_idle();
    while (event_q.size() != 0 || items_accepted != items_issued || status_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [TS_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT) cfg_timeout = val;
    else cfg_min_press = val;
    reg_writes++;
  endtask

  // Press length near the counting threshold, or anywhere.
  function automatic logic [TS_W-1:0] pick_length();
    case ($urandom_range(5))
      0: return '0;
      1: return cfg_min_press - 1'b1;
      2: return cfg_min_press;
      3: return cfg_min_press + TS_W'($urandom_range(4000));
      4: return TS_W'($urandom);
      default: return TS_W'($urandom_range(5000));
    endcase
  endfunction

  // Queue a well-formed burst: clicks, ticks around expiry, maybe a re-arm.
  task automatic queue_burst();
    int n;
    logic [TS_W-1:0] rel_ts;
    logic [TS_W-1:0] due;
    n = $urandom_range(1, 5);
    rel_ts = now_ts;
    for (int i = 0; i < n; i++) begin
      push_event(OP_PRESS, now_ts);
      rel_ts = now_ts + pick_length();
      push_event(OP_RELEASE, rel_ts);
      now_ts = rel_ts + TS_W'($urandom_range(1, 2000));
    end
    due = rel_ts + cfg_timeout;
    // expiry while disabled now and then
    if ($urandom_range(99) < 10) push_event(OP_DISABLE, rel_ts);
    if ($urandom_range(99) < 50) push_event(OP_TICK, due - 1'b1);
    case ($urandom_range(3))
      0: push_event(OP_TICK, due);
      1: push_event(OP_TICK, due + TS_W'($urandom_range(1, 3000)));
      2: push_event(OP_TICK, TS_W'($urandom));
      default: ;
    endcase
    now_ts = due + TS_W'($urandom_range(1, 100));
    if ($urandom_range(99) < 60) begin
      push_event(OP_DISABLE, now_ts);
      push_event(OP_ENABLE, now_ts + 1'b1);
      now_ts = now_ts + 2'd2;
    end else if ($urandom_range(99) < 30) begin
      push_event(OP_ENABLE, now_ts);
    end
  endtask

  task automatic run_random(int n_items);
    int start;
    start = items_issued;
    while (items_issued - start < n_items) begin
      if ($urandom_range(99) < 15) push_event(3'($urandom_range(7)), TS_W'($urandom));
      else queue_burst();
    end
  endtask

  // Drive events; predict each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_q.push_back(predict_click_state(operation, timestamp));
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          operation <= event_q[0].op;
          timestamp <= event_q[0].ts;
          event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each status item against the oldest expectation; drive stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("status item with nothing expected");
          mismatches++;
        end else begin
          if (report_ready !== status_q[0].ready) begin
            $error("report_ready: expected %0d, got %0d", status_q[0].ready, report_ready);
            mismatches++;
          end
          if (report_clicks !== status_q[0].clicks) begin
            $error("report_clicks: expected %0d, got %0d", status_q[0].clicks, report_clicks);
            mismatches++;
          end
          if (report_seconds !== status_q[0].seconds) begin
            $error("report_seconds: expected %0d, got %0d", status_q[0].seconds,
                   report_seconds);
            mismatches++;
          end
          if (report_new !== status_q[0].fresh) begin
            $error("report_new: expected %0d, got %0d", status_q[0].fresh, report_new);
            mismatches++;
          end
          if (clicks_pending !== status_q[0].pending) begin
            $error("clicks_pending: expected %0d, got %0d", status_q[0].pending,
                   clicks_pending);
            mismatches++;
          end
          if (enabled_now !== status_q[0].enabled) begin
            $error("enabled_now: expected %0d, got %0d", status_q[0].enabled, enabled_now);
            mismatches++;
          end
          if (status_q[0].fresh) fresh_reports++;
          status_q.pop_front();
          status_checked++;
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_TIMEOUT;
    cfg_data  = '0;
    cfg_timeout   = TIMEOUT_RESET;
    cfg_min_press = MIN_PRESS_RESET;
    btn_on       = 1'b1;
    held         = 1'b0;
    burst_clicks = '0;
    press_t0     = '0;
    last_len     = '0;
    timer_run    = 1'b0;
    timer_t0     = '0;
    report_held  = 1'b0;
    rep_clicks   = '0;
    rep_secs     = '0;
    send_idle_pct = 10;
    recv_idle_pct = 67;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed events with reset configuration
    push_event(OP_RELEASE, 24'd100);           // release with no press
    push_event(OP_TICK, 24'd200);              // nothing armed
    push_event(OP_PRESS, 24'd0);
    push_event(OP_RELEASE, 24'd5000);          // counted
    push_event(OP_PRESS, 24'd6000);
    push_event(OP_RELEASE, 24'd9299);          // one tick too short
    push_event(OP_TICK, 24'd25682);            // one tick before expiry
    push_event(OP_TICK, 24'd25683);            // expiry latches a report
    push_event(OP_PRESS, 24'hFFFFF0);
    push_event(OP_RELEASE, 24'hFFFFEF);        // wrapped, longest press
    push_event(OP_TICK, 24'h003FEF);           // report already waiting
    push_event(OP_ENABLE, 24'd1);              // already enabled
    push_event(OP_DISABLE, 24'd2);
    push_event(OP_PRESS, 24'd3);               // ignored while disabled
    push_event(OP_RELEASE, 24'd4000);
    push_event(OP_ENABLE, 24'd5000);           // clears the waiting report
    push_event(OP_PRESS, 24'd6000);
    push_event(OP_RELEASE, 24'd9300);          // exactly the minimum
    push_event(OP_DISABLE, 24'd9400);
    push_event(OP_TICK, 24'd25684);            // expiry while disabled
    push_event(OP_ENABLE, 24'hFFFFFF);
    for (int c = OP_DISABLE + 1; c < 8; c++) push_event(3'(c), 24'hFFFFFF);
    push_event(OP_PRESS, 24'hFFFFFF);
    push_event(OP_RELEASE, 24'h0FFFFF);
    push_event(OP_TICK, 24'h0FFFFF + TIMEOUT_RESET);
    wait_idle();

    // shortest timeout, every press counts
    write_reg(REG_TIMEOUT, 24'd1);
    write_reg(REG_MIN_PRESS, 24'd0);
    run_random(150);
    wait_idle();

    // swap idling sides; longest timeout and threshold
    send_idle_pct = 67;
    recv_idle_pct = 10;
    write_reg(REG_TIMEOUT, 24'hFFFFFF);
    write_reg(REG_MIN_PRESS, 24'hFFFFFF);
    run_random(150);
    wait_idle();

    // no idling; zero timeout and a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_TIMEOUT, 24'd0);
    write_reg(REG_MIN_PRESS, TS_W'($urandom_range(3000)));
    run_random(150);
    hold_req = 1'b1;
    wait_idle();

    // random mid-range settings, then a saturating burst
    write_reg(REG_TIMEOUT, TS_W'($urandom_range(1, 20000)));
    write_reg(REG_MIN_PRESS, TS_W'($urandom_range(1, 5000)));
    run_random(120);
    push_event(OP_DISABLE, now_ts);
    push_event(OP_ENABLE, now_ts + 1'b1);
    for (int i = 0; i < 260; i++) push_event(OP_PRESS, now_ts + 2'd2);
    push_event(OP_RELEASE, now_ts + 2'd2 + cfg_min_press);
    push_event(OP_TICK, now_ts + 2'd2 + cfg_min_press + cfg_timeout);
    now_ts = now_ts + 2'd2 + cfg_min_press + cfg_timeout + 1'b1;
    run_random(30);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Run: %0d events, %0d status items checked, %0d fresh reports latched",
             items_accepted, status_checked, fresh_reports);
    $display("Run: %0d register writes across five settings, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
